@@ hw/rtl/hls_pkg.sv @@
package hls_pkg;

	// channel and result widths
	localparam int COLOR_W = 24;
	localparam int CHAN_W  = 8;
	localparam int RES_W   = 8;
	localparam int SUM_W   = CHAN_W + 1;

	// 0-240 scale
	localparam int HLS_MAX     = 240;
	localparam int RGB_MAX     = 255;
	localparam int DELTA_SCALE = HLS_MAX / 6;
	localparam int HUE_GREEN   = HLS_MAX / 3;
	localparam int HUE_BLUE    = (2 * HLS_MAX) / 3;
	localparam int HUE_GREY    = (2 * HLS_MAX) / 3;

	// luminance at or below half scale exactly when max + min is at most this
	localparam int SAT_SPLIT = 256;

	// luminance = (sum*240 + 255) / 510 = (16*sum + 17) / 34, by reciprocal
	localparam int LUM_DIV   = 34;
	localparam int LUM_SHIFT = 18;
	localparam int LUM_RECIP = ((1 << LUM_SHIFT) + LUM_DIV - 1) / LUM_DIV;
	localparam int LUM_X_W   = 13;
	localparam int LUM_P_W   = 26;

	// shared divider shape: saturation lane plus three hue delta lanes
	localparam int DIV_LANES = 4;
	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 9;
	localparam int DIV_QUO_W = 8;

	localparam int LANE_SAT = 0;
	localparam int LANE_DR  = 1;
	localparam int LANE_DG  = 2;
	localparam int LANE_DB  = 3;

	// which channel holds the maximum
	localparam logic [1:0] SEL_RED   = 2'd0;
	localparam logic [1:0] SEL_GREEN = 2'd1;
	localparam logic [1:0] SEL_BLUE  = 2'd2;

	// data that rides alongside the divider lanes
	typedef struct packed {
		logic              grey;
		logic [1:0]        sel;
		logic [RES_W-1:0]  lum;
	} hls_side_t;

endpackage

@@ hw/rtl/hls_div_pipe.sv @@
module hls_div_pipe #(
	parameter int LANES  = hls_pkg::DIV_LANES,
	parameter int NUM_W  = hls_pkg::DIV_NUM_W,
	parameter int DEN_W  = hls_pkg::DIV_DEN_W,
	parameter int QUO_W  = hls_pkg::DIV_QUO_W,
	parameter int SIDE_W = $bits(hls_pkg::hls_side_t)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num [LANES],
	input  logic [DEN_W-1:0]  in_den [LANES],
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo [LANES],
	output logic [SIDE_W-1:0] out_side
);

	localparam int CW = NUM_W + DEN_W;

	// one quotient bit per stage, most significant first
	logic              vld_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W][LANES];
	logic [SIDE_W-1:0] side_s [QUO_W];
	logic [NUM_W-1:0]  rem_s  [QUO_W-1][LANES];
	logic [DEN_W-1:0]  den_s  [QUO_W-1][LANES];

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic              v_in;
		logic [SIDE_W-1:0] side_in;
		logic [NUM_W-1:0]  rem_in [LANES];
		logic [DEN_W-1:0]  den_in [LANES];
		logic [QUO_W-1:0]  quo_in [LANES];
		logic [CW-1:0]     trial  [LANES];
		logic              ge     [LANES];
		logic [NUM_W-1:0]  rem_nx [LANES];
		logic [QUO_W-1:0]  quo_nx [LANES];

		// stage operands
		if (k == 0) begin : g_first
			always_comb begin
				v_in    = in_valid;
				side_in = in_side;
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = in_num[l];
					den_in[l] = in_den[l];
					quo_in[l] = '0;
				end
			end
		end else begin : g_next
			always_comb begin
				v_in    = vld_s[k-1];
				side_in = side_s[k-1];
				for (int l = 0; l < LANES; l++) begin
					rem_in[l] = rem_s[k-1][l];
					den_in[l] = den_s[k-1][l];
					quo_in[l] = quo_s[k-1][l];
				end
			end
		end

		// compare and subtract the shifted divisor
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				trial[l]  = CW'(den_in[l]) << (QUO_W - 1 - k);
				ge[l]     = CW'(rem_in[l]) >= trial[l];
				rem_nx[l] = ge[l] ? NUM_W'(CW'(rem_in[l]) - trial[l]) : rem_in[l];
				quo_nx[l] = {quo_in[l][QUO_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				for (int l = 0; l < LANES; l++) begin
					quo_s[k][l] <= quo_nx[l];
				end
			end
		end

		// remainder and divisor are not needed after the last bit
		if (k < QUO_W - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					for (int l = 0; l < LANES; l++) begin
						rem_s[k][l] <= rem_nx[l];
						den_s[k][l] <= den_in[l];
					end
				end
			end
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];
	assign out_quo   = quo_s[QUO_W-1];

endmodule

@@ hw/rtl/rgb_to_hls_converter_unit.sv @@
// rgb to hls converter, 0-240 scale
//
// input channel (s_*): one packed colour word per transfer, red in bits 7:0,
// green in 15:8, blue in 23:16. output channel (m_*): one word per input,
// hue in bits 7:0, saturation in 15:8, luminance in 23:16.
//
// a new word can be taken on every clock unless the receiver stalls;
// sustained throughput is then one word per cycle. twelve register stages:
// max/min, sums and products, luminance fix-up, eight stages of the shared
// four-lane divider (one quotient bit per stage for saturation and the three
// hue deltas), and the hue combine. the result is held in the output register
// until it is taken.
//
// when the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; nothing is lost or repeated. bubbles travel as empty
// stages. reset clears every valid bit, so the pipeline comes up empty and
// the first word can be accepted right after reset is released.
module rgb_to_hls_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // packed_color[23:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // hue[7:0], saturation[15:8], luminance[23:16]
);

	localparam int CW  = hls_pkg::CHAN_W;
	localparam int SW  = hls_pkg::SUM_W;
	localparam int RW  = hls_pkg::RES_W;
	localparam int NW  = hls_pkg::DIV_NUM_W;
	localparam int DW  = hls_pkg::DIV_DEN_W;
	localparam int QW  = hls_pkg::DIV_QUO_W;
	localparam int NL  = hls_pkg::DIV_LANES;
	localparam int XW  = hls_pkg::LUM_X_W;
	localparam int PW  = hls_pkg::LUM_P_W;
	localparam int HW  = 10;
	localparam int SDW = $bits(hls_pkg::hls_side_t);

	logic adv;

	// pipeline moves whenever the output register is free or being taken
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: unpack, max and min, winning channel
	logic [CW-1:0] r_c, g_c, b_c, top_c, bot_c;
	logic [1:0]    sel_c;

	logic          vld_s1;
	logic [CW-1:0] r_s1, g_s1, b_s1, top_s1, bot_s1;
	logic [1:0]    sel_s1;

	always_comb begin
		r_c = s_tdata[7:0];
		g_c = s_tdata[15:8];
		b_c = s_tdata[23:16];
		if (r_c >= g_c && r_c >= b_c) begin
			sel_c = hls_pkg::SEL_RED;
			top_c = r_c;
		end else if (g_c >= b_c) begin
			sel_c = hls_pkg::SEL_GREEN;
			top_c = g_c;
		end else begin
			sel_c = hls_pkg::SEL_BLUE;
			top_c = b_c;
		end
		bot_c = r_c;
		if (g_c < bot_c) bot_c = g_c;
		if (b_c < bot_c) bot_c = b_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s1   <= r_c;
			g_s1   <= g_c;
			b_s1   <= b_c;
			top_s1 <= top_c;
			bot_s1 <= bot_c;
			sel_s1 <= sel_c;
		end
	end

	// stage 2: span, sum, luminance product, divider operands
	logic [CW-1:0] span_c;
	logic [SW-1:0] sum_c, sat_d_c;
	logic [XW-1:0] lum_x_c;
	logic [NW-1:0] num_c [NL];
	logic [DW-1:0] den_c [NL];

	logic          vld_s2, grey_s2;
	logic [1:0]    sel_s2;
	logic [XW-1:0] lum_x_s2;
	logic [PW-1:0] lum_p_s2;
	logic [NW-1:0] num_s2 [NL];
	logic [DW-1:0] den_s2 [NL];

	always_comb begin
		span_c  = top_s1 - bot_s1;
		sum_c   = SW'(top_s1) + SW'(bot_s1);
		lum_x_c = (XW'(sum_c) << 4) + XW'(17);
		// lower half uses max+min, upper half uses 510-(max+min)
		if (sum_c <= SW'(hls_pkg::SAT_SPLIT)) begin
			sat_d_c = sum_c;
		end else begin
			sat_d_c = SW'(2 * hls_pkg::RGB_MAX) - sum_c;
		end
		num_c[hls_pkg::LANE_SAT] = NW'(span_c) * NW'(hls_pkg::HLS_MAX) + NW'(sat_d_c[SW-1:1]);
		num_c[hls_pkg::LANE_DR]  = NW'(top_s1 - r_s1) * NW'(hls_pkg::DELTA_SCALE)
			+ NW'(span_c[CW-1:1]);
		num_c[hls_pkg::LANE_DG]  = NW'(top_s1 - g_s1) * NW'(hls_pkg::DELTA_SCALE)
			+ NW'(span_c[CW-1:1]);
		num_c[hls_pkg::LANE_DB]  = NW'(top_s1 - b_s1) * NW'(hls_pkg::DELTA_SCALE)
			+ NW'(span_c[CW-1:1]);
		den_c[hls_pkg::LANE_SAT] = DW'(sat_d_c);
		den_c[hls_pkg::LANE_DR]  = DW'(span_c);
		den_c[hls_pkg::LANE_DG]  = DW'(span_c);
		den_c[hls_pkg::LANE_DB]  = DW'(span_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			grey_s2  <= (span_c == '0);
			sel_s2   <= sel_s1;
			lum_x_s2 <= lum_x_c;
			lum_p_s2 <= PW'(lum_x_c) * PW'(hls_pkg::LUM_RECIP);
			num_s2   <= num_c;
			den_s2   <= den_c;
		end
	end

	// stage 3: luminance quotient with one-step correction
	logic [RW-1:0]       lum_q;
	logic [XW-1:0]       lum_rem;
	hls_pkg::hls_side_t  side_c;

	logic                vld_s3;
	hls_pkg::hls_side_t  side_s3;
	logic [NW-1:0]       num_s3 [NL];
	logic [DW-1:0]       den_s3 [NL];

	always_comb begin
		lum_q   = lum_p_s2[PW-1 -: RW];
		lum_rem = lum_x_s2 - XW'(XW'(lum_q) * XW'(hls_pkg::LUM_DIV));
		side_c.grey = grey_s2;
		side_c.sel  = sel_s2;
		side_c.lum  = (lum_rem >= XW'(hls_pkg::LUM_DIV)) ? lum_q + RW'(1) : lum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_c;
			num_s3  <= num_s2;
			den_s3  <= den_s2;
		end
	end

	// stages 4 to 11: saturation and hue delta divisions
	logic           div_vld;
	logic [QW-1:0]  div_quo [NL];
	logic [SDW-1:0] div_side;

	hls_div_pipe #(
		.LANES  (NL),
		.NUM_W  (NW),
		.DEN_W  (DW),
		.QUO_W  (QW),
		.SIDE_W (SDW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (vld_s3),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_side   (SDW'(side_s3)),
		.out_valid (div_vld),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// stage 12: hue from deltas, wrap, grey override, output register
	hls_pkg::hls_side_t side_d;
	logic signed [HW-1:0] dr, dg, db, hue_raw, hue_wrap;
	logic [RW-1:0] hue_c, sat_c;

	logic          vld_s12;
	logic [RW-1:0] hue_s12, sat_s12, lum_s12;

	always_comb begin
		side_d = hls_pkg::hls_side_t'(div_side);
		dr = $signed(HW'(div_quo[hls_pkg::LANE_DR]));
		dg = $signed(HW'(div_quo[hls_pkg::LANE_DG]));
		db = $signed(HW'(div_quo[hls_pkg::LANE_DB]));
		case (side_d.sel)
			hls_pkg::SEL_RED:   hue_raw = db - dg;
			hls_pkg::SEL_GREEN: hue_raw = $signed(HW'(hls_pkg::HUE_GREEN)) + dr - db;
			default:            hue_raw = $signed(HW'(hls_pkg::HUE_BLUE)) + dg - dr;
		endcase
		if (hue_raw < $signed(HW'(0))) begin
			hue_wrap = hue_raw + $signed(HW'(hls_pkg::HLS_MAX));
		end else if (hue_raw > $signed(HW'(hls_pkg::HLS_MAX))) begin
			hue_wrap = hue_raw - $signed(HW'(hls_pkg::HLS_MAX));
		end else begin
			hue_wrap = hue_raw;
		end
		if (side_d.grey) begin
			hue_c = RW'(hls_pkg::HUE_GREY);
			sat_c = '0;
		end else begin
			hue_c = hue_wrap[RW-1:0];
			sat_c = div_quo[hls_pkg::LANE_SAT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s12 <= 1'b0;
		end else if (adv) begin
			vld_s12 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s12 <= hue_c;
			sat_s12 <= sat_c;
			lum_s12 <= side_d.lum;
		end
	end

	assign m_tvalid = vld_s12;
	assign m_tdata  = {lum_s12, sat_s12, hue_s12};

	// every delivered field stays on the 0-240 scale
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd240 && m_tdata[15:8] <= 8'd240
			&& m_tdata[23:16] <= 8'd240))
		else $error("result field out of 0-240 range");

	// an accepted word occupies the first stage on the next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted word missing from first stage");

	// max is never below min for a live word
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (top_s1 >= bot_s1))
		else $error("max below min in first stage");

	// reciprocal estimate is off by at most one step
	a_lum_fix: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> (lum_rem < XW'(2 * hls_pkg::LUM_DIV)))
		else $error("luminance correction insufficient");

endmodule

@@ tb/testbench.sv @@
module testbench;

	localparam int PIPE_DEPTH  = 12;
	localparam int CYCLE_LIMIT = 250000;
	localparam int RANDOM_WORDS = 1750;

	// result word, hue in the low byte
	typedef struct packed {
		logic [hls_pkg::RES_W-1:0] lum;
		logic [hls_pkg::RES_W-1:0] sat;
		logic [hls_pkg::RES_W-1:0] hue;
	} hls_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [hls_pkg::COLOR_W-1:0] s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [23:0]                 m_tdata;

	logic [hls_pkg::COLOR_W-1:0] colors_to_send[$];
	hls_t                        predicted_hls[$];

	int cycle_count = 0;
	int sent_count = 0;
	int checked_count = 0;
	int error_count = 0;
	int grey_count = 0;
	int wrap_count = 0;

	rgb_to_hls_converter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// one hue delta, rounded
	function automatic int scaled_delta(input int top, input int chan, input int span);
		return ((top - chan) * (hls_pkg::HLS_MAX / 6) + span / 2) / span;
	endfunction

	// hue, saturation and luminance of one packed colour
	function automatic hls_t hls_from_rgb(input logic [hls_pkg::COLOR_W-1:0] color);
		int r, g, b, top, bot, span, sum, rest, lum, sat, hue, dr, dg, db;
		hls_t res;
		r = color[7:0];
		g = color[15:8];
		b = color[23:16];
		top = r;
		bot = r;
		if (g > top) top = g;
		if (b > top) top = b;
		if (g < bot) bot = g;
		if (b < bot) bot = b;
		lum = ((top + bot) * hls_pkg::HLS_MAX + hls_pkg::RGB_MAX) / (2 * hls_pkg::RGB_MAX);
		if (top == bot) begin
			sat = 0;
			hue = hls_pkg::HUE_GREY;
		end else begin
			span = top - bot;
			sum = top + bot;
			if (lum <= hls_pkg::HLS_MAX / 2) begin
				sat = (span * hls_pkg::HLS_MAX + sum / 2) / sum;
			end else begin
				rest = 2 * hls_pkg::RGB_MAX - sum;
				sat = (span * hls_pkg::HLS_MAX + rest / 2) / rest;
			end
			dr = scaled_delta(top, r, span);
			dg = scaled_delta(top, g, span);
			db = scaled_delta(top, b, span);
			// ties go to red, then green
			if (r == top) begin
				hue = db - dg;
			end else if (g == top) begin
				hue = hls_pkg::HUE_GREEN + dr - db;
			end else begin
				hue = hls_pkg::HUE_BLUE + dg - dr;
			end
			if (hue < 0) hue += hls_pkg::HLS_MAX;
			if (hue > hls_pkg::HLS_MAX) hue -= hls_pkg::HLS_MAX;
		end
		res.hue = hue[hls_pkg::RES_W-1:0];
		res.sat = sat[hls_pkg::RES_W-1:0];
		res.lum = lum[hls_pkg::RES_W-1:0];
		return res;
	endfunction

	function automatic logic [hls_pkg::COLOR_W-1:0] pack_rgb(input int r, input int g,
			input int b);
		return {b[7:0], g[7:0], r[7:0]};
	endfunction

	// random colour, biased toward the corners of the conversion
	function automatic logic [hls_pkg::COLOR_W-1:0] random_color();
		int c[3];
		int top, bot, tmp, i, j;
		logic [hls_pkg::COLOR_W-1:0] color;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: color = hls_pkg::COLOR_W'($urandom());
			5: begin
				// grey
				tmp = $urandom_range(0, 255);
				color = pack_rgb(tmp, tmp, tmp);
			end
			6: begin
				// two channels tied at the maximum
				top = $urandom_range(1, 255);
				bot = $urandom_range(0, top - 1);
				case ($urandom_range(0, 2))
					0: color = pack_rgb(top, top, bot);
					1: color = pack_rgb(top, bot, top);
					default: color = pack_rgb(bot, top, top);
				endcase
			end
			7: begin
				// max + min around the saturation split
				top = $urandom_range(130, 254);
				bot = 254 + $urandom_range(0, 4) - top;
				c[0] = top;
				c[1] = bot;
				c[2] = $urandom_range(bot, top);
				for (i = 2; i > 0; i--) begin
					j = $urandom_range(0, i);
					tmp = c[i];
					c[i] = c[j];
					c[j] = tmp;
				end
				color = pack_rgb(c[0], c[1], c[2]);
			end
			8: begin
				// red on top, blue above green: hue goes negative and wraps
				top = $urandom_range(2, 255);
				bot = $urandom_range(0, top - 2);
				color = pack_rgb(top, bot, $urandom_range(bot + 1, top - 1));
			end
			default: begin
				for (i = 0; i < 3; i++) begin
					case ($urandom_range(0, 4))
						0: c[i] = 0;
						1: c[i] = 1;
						2: c[i] = 254;
						3: c[i] = 255;
						default: c[i] = $urandom_range(0, 255);
					endcase
				end
				color = pack_rgb(c[0], c[1], c[2]);
			end
		endcase
		return color;
	endfunction

	// stimulus, reset and end of run
	initial begin
		logic [hls_pkg::COLOR_W-1:0] color;
		hls_t res;
		// corners, primaries, ties, wrap and split cases
		colors_to_send.push_back(24'h000000);
		colors_to_send.push_back(24'hFFFFFF);
		colors_to_send.push_back(24'h0000FF);
		colors_to_send.push_back(24'h00FF00);
		colors_to_send.push_back(24'hFF0000);
		colors_to_send.push_back(24'h00FFFF);
		colors_to_send.push_back(24'hFFFF00);
		colors_to_send.push_back(24'hFF00FF);
		colors_to_send.push_back(24'h808080);
		colors_to_send.push_back(24'h555555);
		colors_to_send.push_back(24'hAAAAAA);
		colors_to_send.push_back(24'h8000FF);
		colors_to_send.push_back(24'h0100FF);
		colors_to_send.push_back(24'h01FF00);
		colors_to_send.push_back(24'hFFFF01);
		colors_to_send.push_back(24'h6437C8);
		colors_to_send.push_back(24'h6438C8);
		colors_to_send.push_back(24'h6439C8);
		colors_to_send.push_back(24'h000001);
		colors_to_send.push_back(24'hFEFFFF);
		colors_to_send.push_back(24'h7F7F80);
		colors_to_send.push_back(24'h010101);
		for (int n = 0; n < RANDOM_WORDS; n++) colors_to_send.push_back(random_color());
		foreach (colors_to_send[k]) begin
			color = colors_to_send[k];
			res = hls_from_rgb(color);
			if (res.sat == 0) grey_count++;
			if (color[7:0] > color[15:8] && color[7:0] >= color[23:16] &&
					color[23:16] > color[15:8]) wrap_count++;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (colors_to_send.size() > 0 || predicted_hls.size() > 0) @(posedge clk);
		repeat (3 * PIPE_DEPTH) @(posedge clk);

		$display("%0d colours sent, %0d results checked (%0d grey, %0d with wrapped hue)",
			sent_count, checked_count, grey_count, wrap_count);
		$display("%0d mismatches under bursty input and a varying output stall pattern",
			error_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// input driver: bursts of random length with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predicted_hls.push_back(hls_from_rgb(s_tdata));
				void'(colors_to_send.pop_front());
				sent_count++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (colors_to_send.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= colors_to_send[0];
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// output stall pattern, switching mode every so often
	int ready_mode = 0;
	int ready_left = 0;
	always @(posedge clk) begin
		if (ready_left <= 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(20, 200);
		end
		ready_left--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycle_count % 7) >= 3);
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		hls_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (predicted_hls.size() == 0) begin
				$display("%0t: result word expected none got %h", $time, m_tdata);
				error_count++;
			end else begin
				want = predicted_hls.pop_front();
				checked_count++;
				if (got.hue !== want.hue) begin
					$display("%0t: hue expected %0d got %0d", $time, want.hue, got.hue);
					error_count++;
				end
				if (got.sat !== want.sat) begin
					$display("%0t: saturation expected %0d got %0d", $time, want.sat, got.sat);
					error_count++;
				end
				if (got.lum !== want.lum) begin
					$display("%0t: luminance expected %0d got %0d", $time, want.lum, got.lum);
					error_count++;
				end
			end
		end
	end

endmodule
